@@ src/essd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// essd_pkg: shared types and constants for the segment store block
// Request codes, the stored segment layout, controller states and the square
// root handshake.
// ----------------------------------------------------------------------------
package essd_pkg;

  localparam int unsigned CoordW = 31;
  localparam int unsigned SegW   = 4 * CoordW;
  localparam int unsigned LenW   = 48;
  localparam int unsigned CntW   = 10;
  localparam int unsigned SqW    = 64;
  localparam int unsigned RootW  = 32;

  typedef enum logic [1:0] {
    REQ_INS_A = 2'd0,
    REQ_INS_B = 2'd1,
    REQ_CMP   = 2'd2,
    REQ_CLR   = 2'd3
  } req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
  } seg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CHK,
    ST_CMP_OUT_RD,
    ST_CMP_OUT_WAIT,
    ST_CMP_IN_RD,
    ST_CMP_IN_CHK,
    ST_CMP_LEN,
    ST_CMP_SQRT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [SqW-1:0]   value;
  } sqrt_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [RootW-1:0] root;
  } sqrt_rsp_t;

endpackage : essd_pkg
`default_nettype wire

@@ src/essd_sqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// essd_sqrt: iterative integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module essd_sqrt (
  input  wire                 clk,
  input  wire                 rst_n,
  input  essd_pkg::sqrt_req_t req,
  output essd_pkg::sqrt_rsp_t rsp
);

  localparam int unsigned SqW   = essd_pkg::SqW;
  localparam int unsigned RootW = essd_pkg::RootW;

  logic [SqW-1:0]   rem_r, rem_nxt;
  logic [SqW-1:0]   val_r, val_nxt;
  logic [RootW-1:0] root_r, root_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [SqW-1:0]   trial;
  logic [SqW-1:0]   rem_sh;

  // Restoring digit step: bring down two bits, try 4*root+1
  always_comb begin
    rem_nxt  = rem_r;
    val_nxt  = val_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[SqW-3:0], val_r[SqW-1:SqW-2]};
    trial    = {{(SqW-RootW-2){1'b0}}, root_r, 2'b01};
    if (req.start) begin
      rem_nxt  = '0;
      val_nxt  = req.value;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      val_nxt = {val_r[SqW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[RootW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[RootW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(RootW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    val_r  <= val_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule : essd_sqrt
`default_nettype wire

@@ src/edge_set_symmetric_difference.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// edge_set_symmetric_difference: two segment stores with symmetric difference
// Insert, compare and clear requests over two on-chip segment memories.
// ----------------------------------------------------------------------------
// Each request gives exactly one result. An insert scans the target store
// through its single read port entry by entry (read, then compare). A
// compare takes each entry of store A and then of store B in turn, scans
// the other store entry by entry (read, then compare), and takes the square
// root of the squared length of each unmatched segment. A clear resets both
// fill counts. No clearing pass is needed after reset: fill counts mark the
// valid entries.
// ----------------------------------------------------------------------------
module edge_set_symmetric_difference #(
  parameter int unsigned MAX_EDGES = 256
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire         [15:0] cfg_wdata,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire          [1:0] in_req_type,
  input  wire signed  [30:0] in_first_x,
  input  wire signed  [30:0] in_first_y,
  input  wire signed  [30:0] in_second_x,
  input  wire signed  [30:0] in_second_y,
  output logic               out_valid,
  input  wire                out_ready,
  output logic         [9:0] out_unmatched_count,
  output logic        [47:0] out_diff_length,
  output logic               out_was_duplicate,
  output logic               out_store_full
);

  localparam int unsigned AW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned FW     = $clog2(MAX_EDGES + 1);
  localparam int unsigned CoordW = essd_pkg::CoordW;
  localparam int unsigned LenW   = essd_pkg::LenW;
  localparam int unsigned CntW   = essd_pkg::CntW;
  localparam logic [CntW-1:0] CntMax = '1;
  localparam logic [LenW-1:0] LenMax = '1;

  // Segment memories
  essd_pkg::seg_t mem_a [MAX_EDGES];
  essd_pkg::seg_t mem_b [MAX_EDGES];
  essd_pkg::seg_t rd_a_r, rd_b_r;
  logic [AW-1:0]  ra_a, ra_b, wa;
  logic           we_a, we_b;
  essd_pkg::seg_t wd;

  always_ff @(posedge clk) begin
    if (we_a) mem_a[wa] <= wd;
    rd_a_r <= mem_a[ra_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) mem_b[wa] <= wd;
    rd_b_r <= mem_b[ra_b];
  end

  // Registers
  essd_pkg::state_t state_r, state_nxt;
  logic [15:0]      tol_r;
  logic [FW-1:0]    fill_a_r, fill_a_nxt, fill_b_r, fill_b_nxt;
  logic [FW-1:0]    oi_r, oi_nxt, ii_r, ii_nxt;
  logic             side_r, side_nxt;   // 0: A against B, 1: B against A
  logic             tgt_r, tgt_nxt;
  essd_pkg::seg_t   seg_r, seg_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [LenW-1:0]  len_r, len_nxt;
  logic             dup_r, dup_nxt, full_r, full_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [63:0]      sq_r, sq_nxt;
  logic             found_r, found_nxt;

  essd_pkg::sqrt_req_t sq_req;
  essd_pkg::sqrt_rsp_t sq_rsp;

  essd_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (sq_req),
    .rsp  (sq_rsp)
  );

  function automatic logic near_eq(input logic signed [CoordW-1:0] a,
                                   input logic signed [CoordW-1:0] b,
                                   input logic [15:0] tol);
    logic signed [CoordW:0] d;
    logic [CoordW:0]        m;
    d = {a[CoordW-1], a} - {b[CoordW-1], b};
    m = d[CoordW] ? (~d + 1'b1) : d;
    return m <= {{(CoordW-15){1'b0}}, tol};
  endfunction

  function automatic logic seg_eq(input essd_pkg::seg_t p, input essd_pkg::seg_t q,
                                  input logic [15:0] tol);
    return near_eq(p.ax, q.ax, tol) && near_eq(p.ay, q.ay, tol) &&
           near_eq(p.bx, q.bx, tol) && near_eq(p.by, q.by, tol);
  endfunction

  // Canonical order of the incoming segment
  essd_pkg::seg_t in_seg, canon;
  always_comb begin
    in_seg = '{ax: in_first_x, ay: in_first_y, bx: in_second_x, by: in_second_y};
    canon  = in_seg;
    if ((in_seg.ax > in_seg.bx) ||
        (near_eq(in_seg.ax, in_seg.bx, tol_r) && (in_seg.ay > in_seg.by))) begin
      canon = '{ax: in_seg.bx, ay: in_seg.by, bx: in_seg.ax, by: in_seg.ay};
    end
  end

  // Squared length of the held segment
  logic [CoordW:0] dxs, dys, ux, uy;
  always_comb begin
    dxs = {seg_r.bx[CoordW-1], seg_r.bx} - {seg_r.ax[CoordW-1], seg_r.ax};
    dys = {seg_r.by[CoordW-1], seg_r.by} - {seg_r.ay[CoordW-1], seg_r.ay};
    ux  = dxs[CoordW] ? (~dxs + 1'b1) : dxs;
    uy  = dys[CoordW] ? (~dys + 1'b1) : dys;
  end

  logic [63:0] ux2_r, uy2_r;
  always_ff @(posedge clk) begin
    ux2_r <= 64'(ux) * 64'(ux);
    uy2_r <= 64'(uy) * 64'(uy);
  end

  logic [FW-1:0]  n_out, n_in;
  essd_pkg::seg_t rd_in, rd_out;
  logic [LenW:0]  len_sum;

  // Controller
  always_comb begin
    state_nxt  = state_r;
    fill_a_nxt = fill_a_r;
    fill_b_nxt = fill_b_r;
    oi_nxt     = oi_r;
    ii_nxt     = ii_r;
    side_nxt   = side_r;
    tgt_nxt    = tgt_r;
    seg_nxt    = seg_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    dup_nxt    = dup_r;
    full_nxt   = full_r;
    found_nxt  = found_r;
    sq_nxt     = sq_r;
    ovalid_nxt = ovalid_r;
    in_ready   = 1'b0;
    we_a       = 1'b0;
    we_b       = 1'b0;
    wa         = tgt_r ? fill_b_r[AW-1:0] : fill_a_r[AW-1:0];
    wd         = seg_r;
    sq_req     = '{start: 1'b0, value: sq_r};
    n_out      = side_r ? fill_b_r : fill_a_r;
    n_in       = side_r ? fill_a_r : fill_b_r;
    rd_out     = side_r ? rd_b_r : rd_a_r;
    rd_in      = side_r ? rd_a_r : rd_b_r;
    ra_a       = ii_r[AW-1:0];
    ra_b       = ii_r[AW-1:0];
    len_sum    = {1'b0, len_r} + {{(LenW-32+1){1'b0}}, sq_rsp.root};

    if (out_valid && out_ready) ovalid_nxt = 1'b0;

    case (state_r)
      essd_pkg::ST_IDLE: begin
        in_ready = !ovalid_r;
        if (in_valid && in_ready) begin
          cnt_nxt  = '0;
          len_nxt  = '0;
          dup_nxt  = 1'b0;
          full_nxt = 1'b0;
          ii_nxt   = '0;
          oi_nxt   = '0;
          side_nxt = 1'b0;
          seg_nxt  = canon;
          tgt_nxt  = in_req_type[0];
          case (essd_pkg::req_t'(in_req_type))
            essd_pkg::REQ_INS_A, essd_pkg::REQ_INS_B: state_nxt = essd_pkg::ST_INS_RD;
            essd_pkg::REQ_CMP: state_nxt = essd_pkg::ST_CMP_OUT_RD;
            default: begin
              fill_a_nxt = '0;
              fill_b_nxt = '0;
              state_nxt  = essd_pkg::ST_DONE;
            end
          endcase
        end
      end
      // Issue the read of entry ii of the target store
      essd_pkg::ST_INS_RD: begin
        if (ii_r >= (tgt_r ? fill_b_r : fill_a_r)) begin
          if ((tgt_r ? fill_b_r : fill_a_r) >= FW'(MAX_EDGES)) begin
            full_nxt = 1'b1;
          end else begin
            we_a = !tgt_r;
            we_b = tgt_r;
            if (tgt_r) fill_b_nxt = fill_b_r + 1'b1;
            else       fill_a_nxt = fill_a_r + 1'b1;
          end
          state_nxt = essd_pkg::ST_DONE;
        end else begin
          state_nxt = essd_pkg::ST_INS_CHK;
        end
      end
      essd_pkg::ST_INS_CHK: begin
        ra_a = ii_r[AW-1:0];
        ra_b = ii_r[AW-1:0];
        if (seg_eq(tgt_r ? rd_b_r : rd_a_r, seg_r, tol_r)) begin
          dup_nxt   = 1'b1;
          state_nxt = essd_pkg::ST_DONE;
        end else begin
          ii_nxt    = ii_r + 1'b1;
          state_nxt = essd_pkg::ST_INS_RD;
        end
      end
      // Fetch the next outer segment
      essd_pkg::ST_CMP_OUT_RD: begin
        ra_a = oi_r[AW-1:0];
        ra_b = oi_r[AW-1:0];
        if (oi_r >= n_out) begin
          if (side_r) begin
            state_nxt = essd_pkg::ST_DONE;
          end else begin
            side_nxt = 1'b1;
            oi_nxt   = '0;
          end
        end else begin
          state_nxt = essd_pkg::ST_CMP_OUT_WAIT;
        end
      end
      essd_pkg::ST_CMP_OUT_WAIT: begin
        seg_nxt   = rd_out;
        ii_nxt    = '0;
        found_nxt = 1'b0;
        state_nxt = essd_pkg::ST_CMP_IN_RD;
      end
      essd_pkg::ST_CMP_IN_RD: begin
        if (ii_r >= n_in) begin
          if (found_r) begin
            oi_nxt    = oi_r + 1'b1;
            state_nxt = essd_pkg::ST_CMP_OUT_RD;
          end else begin
            state_nxt = essd_pkg::ST_CMP_LEN;
          end
        end else begin
          state_nxt = essd_pkg::ST_CMP_IN_CHK;
        end
      end
      essd_pkg::ST_CMP_IN_CHK: begin
        if (seg_eq(rd_in, seg_r, tol_r)) begin
          found_nxt = 1'b1;
          ii_nxt    = n_in;
        end else begin
          ii_nxt = ii_r + 1'b1;
        end
        state_nxt = essd_pkg::ST_CMP_IN_RD;
      end
      // Squares are registered; start the root in this state
      essd_pkg::ST_CMP_LEN: begin
        sq_nxt    = ux2_r + uy2_r;
        state_nxt = essd_pkg::ST_CMP_SQRT;
        sq_req    = '{start: 1'b1, value: ux2_r + uy2_r};
      end
      essd_pkg::ST_CMP_SQRT: begin
        if (sq_rsp.done) begin
          if (cnt_r != CntMax) cnt_nxt = cnt_r + 1'b1;
          len_nxt   = len_sum[LenW] ? LenMax : len_sum[LenW-1:0];
          oi_nxt    = oi_r + 1'b1;
          state_nxt = essd_pkg::ST_CMP_OUT_RD;
        end
      end
      essd_pkg::ST_DONE: begin
        ovalid_nxt = 1'b1;
        state_nxt  = essd_pkg::ST_IDLE;
      end
      default: state_nxt = essd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    seg_r   <= seg_nxt;
    cnt_r   <= cnt_nxt;
    len_r   <= len_nxt;
    dup_r   <= dup_nxt;
    full_r  <= full_nxt;
    oi_r    <= oi_nxt;
    ii_r    <= ii_nxt;
    side_r  <= side_nxt;
    tgt_r   <= tgt_nxt;
    found_r <= found_nxt;
    sq_r    <= sq_nxt;
    if (!rst_n) begin
      state_r  <= essd_pkg::ST_IDLE;
      fill_a_r <= '0;
      fill_b_r <= '0;
      ovalid_r <= 1'b0;
      tol_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      fill_a_r <= fill_a_nxt;
      fill_b_r <= fill_b_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) tol_r <= cfg_wdata;
    end
  end

  assign out_valid           = ovalid_r;
  assign out_unmatched_count = cnt_r;
  assign out_diff_length     = len_r;
  assign out_was_duplicate   = dup_r;
  assign out_store_full      = full_r;

  // Assertions
  a_fill_a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_a_r <= FW'(MAX_EDGES)) else $error("fill_a exceeds capacity");
  a_fill_b_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_b_r <= FW'(MAX_EDGES)) else $error("fill_b exceeds capacity");
  a_dup_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_was_duplicate && out_store_full))
    else $error("duplicate and full both set");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != essd_pkg::ST_IDLE) |-> !in_ready) else $error("ready while busy");

endmodule : edge_set_symmetric_difference
`default_nettype wire
